>>> rtl/pcrs_pkg.sv
// ----------------------------------------------------------------------------
// pcrs_pkg
// Shared types and codes of the peer connect retry scheduler.
// ----------------------------------------------------------------------------
package pcrs_pkg;

    localparam int unsigned TableDepth = 16;
    localparam int unsigned MaxResults = 16;
    localparam int unsigned AddrW      = 48;
    localparam int unsigned TimeW      = 32;
    localparam int unsigned RetryW     = 4;
    localparam int unsigned LimitW     = 10;
    localparam int unsigned DelayW     = 16;
    localparam int unsigned CfgIdxW    = 2;
    localparam int unsigned CfgDataW   = 16;

    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_SUCCESS = 2'd1;
    localparam logic [1:0] CMD_FAILURE = 2'd2;
    localparam logic [1:0] CMD_TICK    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_KNOWN     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;

    localparam logic [CfgIdxW-1:0] REG_LOCAL_LIMIT  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_GLOBAL_LIMIT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_RETRY_DELAY  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_RETRY_LIMIT  = 2'd3;

    localparam logic [RetryW-1:0] RetryMax = 4'd15;

    typedef struct packed {
        logic [AddrW-1:0]  addr;
        logic              connecting;
        logic [RetryW-1:0] retries;
        logic [TimeW-1:0]  retry_time;
    } t_entry;

endpackage

>>> rtl/peer_connect_retry_scheduler_top.sv
// ----------------------------------------------------------------------------
// peer_connect_retry_scheduler_top
// Sorted peer table with add, success, failure and schedule tick commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; results follow on
// o_strobe, one per cycle at most, and o_last marks the final one. The table
// lives in one ram with a registered read, so every table step is a read
// state followed by a check or write state. An add, success or failure
// searches from slot 0, a slot per step; an add then shifts the tail of the
// table down one slot per step to insert, and a success or a failure that
// removes the peer shifts the entries behind it up. A tick reads and checks
// each slot it scans and closes with a flush state. Results cannot be held
// off by the receiver.
module peer_connect_retry_scheduler_top #(
    parameter int unsigned TABLE_DEPTH = pcrs_pkg::TableDepth
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_cmd,
    input  logic [pcrs_pkg::AddrW-1:0]     i_peer_address,
    input  logic [pcrs_pkg::LimitW-1:0]    i_local_connections,
    input  logic [pcrs_pkg::LimitW-1:0]    i_global_connections,
    input  logic [pcrs_pkg::TimeW-1:0]     i_now_time,
    input  logic                           i_cfg_we,
    input  logic [pcrs_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [pcrs_pkg::CfgDataW-1:0]  i_cfg_data,
    output logic                           o_strobe,
    output logic                           o_connect_valid,
    output logic [pcrs_pkg::AddrW-1:0]     o_connect_address,
    output logic [2:0]                     o_status,
    output logic                           o_last
);
    import pcrs_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned NW = $clog2(MaxResults + 1);
    localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);
    localparam logic [NW-1:0] MaxRes = NW'(MaxResults);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_CHK   = 9'b000000100,
        S_SH_RD = 9'b000001000,
        S_SH_WR = 9'b000010000,
        S_INS   = 9'b000100000,
        S_RM_RD = 9'b001000000,
        S_RM_WR = 9'b010000000,
        S_FLUSH = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [LimitW-1:0] r_local_limit, r_global_limit;
    logic [DelayW-1:0] r_retry_delay;
    logic [RetryW-1:0] r_retry_limit;
    logic [CW-1:0] r_used, n_used, r_idx, n_idx, r_pos, n_pos;
    logic [1:0] r_cmd, n_cmd;
    logic [AddrW-1:0] r_addr, n_addr, r_pend_addr, n_pend_addr;
    logic [TimeW-1:0] r_now, n_now;
    logic [LimitW-1:0] r_free, n_free;
    logic [NW-1:0] r_cnt, n_cnt;
    logic r_pend, n_pend;
    logic [2:0] r_hold, n_hold;
    logic r_strobe, n_strobe, r_cv, n_cv, r_last, n_last;
    logic [AddrW-1:0] r_oaddr, n_oaddr;
    logic [2:0] r_ostatus, n_ostatus;

    logic wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    t_entry wr_data, rd_data, new_entry;
    logic [LimitW-1:0] ls, gs;
    logic [RetryW-1:0] inc;
    logic [TimeW:0] tsum;
    logic elig, cont;
    logic [CW-1:0] idx_p1, idx_p2, idx_m1;
    logic [LimitW-1:0] free_nx;
    logic [NW-1:0] cnt_nx;

    pcrs_ram #(.WIDTH($bits(t_entry)), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign busy = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_connect_valid = r_cv;
    assign o_connect_address = r_oaddr;
    assign o_status = r_ostatus;
    assign o_last = r_last;

    assign ls = r_local_limit - i_local_connections;
    assign gs = r_global_limit - i_global_connections;
    assign idx_p1 = r_idx + CW'(1);
    assign idx_p2 = r_idx + CW'(2);
    assign idx_m1 = r_idx - CW'(1);
    assign inc = (rd_data.retries < RetryMax) ? rd_data.retries + RetryW'(1) : RetryMax;
    assign tsum = {1'b0, r_now} + {{(TimeW + 1 - DelayW){1'b0}}, r_retry_delay};
    assign elig = !rd_data.connecting && (rd_data.retry_time <= r_now);
    assign free_nx = elig ? r_free - LimitW'(1) : r_free;
    assign cnt_nx = elig ? r_cnt + NW'(1) : r_cnt;
    assign cont = (idx_p1 < r_used) && (free_nx != '0) && (cnt_nx != MaxRes);

    always_comb begin
        new_entry = '0;
        new_entry.addr = r_addr;
    end

    always_comb begin
        n_state = r_state;
        n_used = r_used;
        n_idx = r_idx;
        n_pos = r_pos;
        n_cmd = r_cmd;
        n_addr = r_addr;
        n_now = r_now;
        n_free = r_free;
        n_cnt = r_cnt;
        n_pend = r_pend;
        n_pend_addr = r_pend_addr;
        n_hold = r_hold;
        n_strobe = 1'b0;
        n_cv = 1'b0;
        n_oaddr = '0;
        n_ostatus = ST_OK;
        n_last = 1'b1;
        wr_en = 1'b0;
        wr_addr = r_idx[IW-1:0];
        wr_data = rd_data;
        rd_en = 1'b0;
        rd_addr = r_idx[IW-1:0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    n_addr = i_peer_address;
                    n_now = i_now_time;
                    n_idx = '0;
                    n_pos = '0;
                    n_cnt = '0;
                    n_pend = 1'b0;
                    case (i_cmd)
                        CMD_TICK: begin
                            if (i_local_connections < r_local_limit &&
                                i_global_connections < r_global_limit) begin
                                n_free = (ls < gs) ? ls : gs;
                            end else begin
                                n_free = '0;
                            end
                            n_state = (r_used == '0 || n_free == '0) ? S_FLUSH : S_RD;
                        end
                        CMD_ADD: begin
                            n_state = (r_used == '0) ? S_INS : S_RD;
                        end
                        default: begin
                            if (r_used == '0) begin
                                n_strobe = 1'b1;
                                n_ostatus = ST_NOT_FOUND;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                rd_en = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_cmd == CMD_TICK) begin
                    if (elig) begin
                        wr_en = 1'b1;
                        wr_data.connecting = 1'b1;
                        if (r_pend) begin
                            n_strobe = 1'b1;
                            n_cv = 1'b1;
                            n_oaddr = r_pend_addr;
                            n_last = 1'b0;
                        end
                        n_pend = 1'b1;
                        n_pend_addr = rd_data.addr;
                    end
                    n_free = free_nx;
                    n_cnt = cnt_nx;
                    if (cont) begin
                        n_idx = idx_p1;
                        n_state = S_RD;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end else if (rd_data.addr == r_addr) begin
                    n_pos = r_idx;
                    if (r_cmd == CMD_ADD) begin
                        n_strobe = 1'b1;
                        n_ostatus = ST_KNOWN;
                        n_state = S_IDLE;
                    end else if (r_cmd == CMD_FAILURE && inc < r_retry_limit) begin
                        wr_en = 1'b1;
                        wr_data.connecting = 1'b0;
                        wr_data.retries = inc;
                        wr_data.retry_time = tsum[TimeW] ? '1 : tsum[TimeW-1:0];
                        n_strobe = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_hold = (r_cmd == CMD_FAILURE) ? ST_REMOVED : ST_OK;
                        if (idx_p1 == r_used) begin
                            n_used = r_used - CW'(1);
                            n_strobe = 1'b1;
                            n_ostatus = n_hold;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_RM_RD;
                        end
                    end
                end else if (rd_data.addr < r_addr && idx_p1 != r_used) begin
                    n_idx = idx_p1;
                    n_state = S_RD;
                end else begin
                    n_pos = (rd_data.addr < r_addr) ? r_used : r_idx;
                    n_idx = r_used;
                    if (r_cmd != CMD_ADD) begin
                        n_strobe = 1'b1;
                        n_ostatus = ST_NOT_FOUND;
                        n_state = S_IDLE;
                    end else if (r_used == Depth) begin
                        n_strobe = 1'b1;
                        n_ostatus = ST_FULL;
                        n_state = S_IDLE;
                    end else begin
                        n_state = (n_pos == r_used) ? S_INS : S_SH_RD;
                    end
                end
            end
            S_SH_RD: begin
                rd_en = 1'b1;
                rd_addr = idx_m1[IW-1:0];
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                wr_en = 1'b1;
                n_idx = idx_m1;
                n_state = (idx_m1 == r_pos) ? S_INS : S_SH_RD;
            end
            S_INS: begin
                wr_en = 1'b1;
                wr_addr = r_pos[IW-1:0];
                wr_data = new_entry;
                n_used = r_used + CW'(1);
                n_strobe = 1'b1;
                n_state = S_IDLE;
            end
            S_RM_RD: begin
                rd_en = 1'b1;
                rd_addr = idx_p1[IW-1:0];
                n_state = S_RM_WR;
            end
            S_RM_WR: begin
                wr_en = 1'b1;
                if (idx_p2 == r_used) begin
                    n_used = r_used - CW'(1);
                    n_strobe = 1'b1;
                    n_ostatus = r_hold;
                    n_state = S_IDLE;
                end else begin
                    n_idx = idx_p1;
                    n_state = S_RM_RD;
                end
            end
            S_FLUSH: begin
                n_strobe = 1'b1;
                n_cv = r_pend;
                n_oaddr = r_pend ? r_pend_addr : '0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_strobe <= 1'b0;
            r_local_limit <= LimitW'(50);
            r_global_limit <= LimitW'(200);
            r_retry_delay <= DelayW'(180);
            r_retry_limit <= RetryW'(3);
        end else begin
            r_state <= n_state;
            r_used <= n_used;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LOCAL_LIMIT:  r_local_limit <= i_cfg_data[LimitW-1:0];
                    REG_GLOBAL_LIMIT: r_global_limit <= i_cfg_data[LimitW-1:0];
                    REG_RETRY_DELAY:  r_retry_delay <= i_cfg_data[DelayW-1:0];
                    REG_RETRY_LIMIT:  r_retry_limit <= i_cfg_data[RetryW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_cmd <= n_cmd;
        r_addr <= n_addr;
        r_now <= n_now;
        r_free <= n_free;
        r_cnt <= n_cnt;
        r_pend <= n_pend;
        r_pend_addr <= n_pend_addr;
        r_hold <= n_hold;
        r_cv <= n_cv;
        r_oaddr <= n_oaddr;
        r_ostatus <= n_ostatus;
        r_last <= n_last;
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= Depth) else $error("table count beyond depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd == CMD_TICK) |=> busy)
        else $error("tick not taken");

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy) else $error("result chain cut short");

    a_req_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_connect_valid |-> o_status == ST_OK)
        else $error("connect request with bad status");

    a_idle_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_connect_valid |-> o_connect_address == '0)
        else $error("address on non-request result");
endmodule

>>> rtl/pcrs_ram.sv
// ----------------------------------------------------------------------------
// pcrs_ram
// Generic simple dual port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcrs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, success, failure and tick commands into the scheduler under
// several register settings and checks every result against a local table
// model of the sorted peer list.
// ----------------------------------------------------------------------------
module testbench;
    import pcrs_pkg::*;

    typedef struct {
        logic              cv;
        logic [AddrW-1:0]  addr;
        logic [2:0]        st;
        logic              last;
    } t_outcome;

    typedef struct {
        logic [1:0]        cmd;
        logic [AddrW-1:0]  addr;
        logic [LimitW-1:0] lc;
        logic [LimitW-1:0] gc;
        logic [TimeW-1:0]  now;
        bit                typed;
        logic [2:0]        st;
    } t_row;

    localparam logic [AddrW-1:0] AddrTop = '1;
    localparam logic [TimeW-1:0] TimeTop = '1;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          i_cmd = CMD_ADD;
    logic [AddrW-1:0]    i_peer_address = '0;
    logic [LimitW-1:0]   i_local_connections = '0;
    logic [LimitW-1:0]   i_global_connections = '0;
    logic [TimeW-1:0]    i_now_time = '0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = REG_LOCAL_LIMIT;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                o_strobe;
    logic                o_connect_valid;
    logic [AddrW-1:0]    o_connect_address;
    logic [2:0]          o_status;
    logic                o_last;

    peer_connect_retry_scheduler_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_cmd               (i_cmd),
        .i_peer_address      (i_peer_address),
        .i_local_connections (i_local_connections),
        .i_global_connections(i_global_connections),
        .i_now_time          (i_now_time),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .o_strobe            (o_strobe),
        .o_connect_valid     (o_connect_valid),
        .o_connect_address   (o_connect_address),
        .o_status            (o_status),
        .o_last              (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // local copy of the peer table and registers
    logic [LimitW-1:0] m_local_limit  = 10'd50;
    logic [LimitW-1:0] m_global_limit = 10'd200;
    logic [DelayW-1:0] m_retry_delay  = 16'd180;
    logic [RetryW-1:0] m_retry_limit  = 4'd3;
    logic [AddrW-1:0]  m_addr [TableDepth];
    logic              m_conn [TableDepth];
    logic [RetryW-1:0] m_retries [TableDepth];
    logic [TimeW-1:0]  m_time [TableDepth];
    int                m_used = 0;

    t_outcome pending_results[$];
    int       errors = 0;
    bit       no_idle = 0;
    logic [AddrW-1:0] peer_pool[$];

    function automatic t_outcome outcome(logic cv, logic [AddrW-1:0] a, logic [2:0] st);
        t_outcome o;
        o.cv = cv;
        o.addr = a;
        o.st = st;
        o.last = 1'b0;
        return o;
    endfunction

    function automatic void drop_entry(int p);
        for (int i = p; i + 1 < m_used; i++) begin
            m_addr[i] = m_addr[i+1];
            m_conn[i] = m_conn[i+1];
            m_retries[i] = m_retries[i+1];
            m_time[i] = m_time[i+1];
        end
        m_used--;
    endfunction

    // computes the results of one command and updates the table copy
    function automatic void predict_command(t_row r);
        t_outcome res[$];
        int p;
        logic [TimeW:0] t;
        logic [LimitW-1:0] slots;
        p = 0;
        while (p < m_used && m_addr[p] < r.addr) p++;
        case (r.cmd)
            CMD_ADD: begin
                if (p < m_used && m_addr[p] == r.addr) begin
                    res.push_back(outcome(1'b0, '0, ST_KNOWN));
                end else if (m_used >= TableDepth) begin
                    res.push_back(outcome(1'b0, '0, ST_FULL));
                end else begin
                    for (int i = m_used; i > p; i--) begin
                        m_addr[i] = m_addr[i-1];
                        m_conn[i] = m_conn[i-1];
                        m_retries[i] = m_retries[i-1];
                        m_time[i] = m_time[i-1];
                    end
                    m_addr[p] = r.addr;
                    m_conn[p] = 1'b0;
                    m_retries[p] = '0;
                    m_time[p] = '0;
                    m_used++;
                    res.push_back(outcome(1'b0, '0, ST_OK));
                end
            end
            CMD_SUCCESS, CMD_FAILURE: begin
                if (!(p < m_used && m_addr[p] == r.addr)) begin
                    res.push_back(outcome(1'b0, '0, ST_NOT_FOUND));
                end else if (r.cmd == CMD_SUCCESS) begin
                    drop_entry(p);
                    res.push_back(outcome(1'b0, '0, ST_OK));
                end else begin
                    m_conn[p] = 1'b0;
                    if (m_retries[p] < RetryMax) m_retries[p]++;
                    if (m_retries[p] < m_retry_limit) begin
                        t = {1'b0, r.now} + m_retry_delay;
                        m_time[p] = t[TimeW] ? TimeTop : t[TimeW-1:0];
                        res.push_back(outcome(1'b0, '0, ST_OK));
                    end else begin
                        drop_entry(p);
                        res.push_back(outcome(1'b0, '0, ST_REMOVED));
                    end
                end
            end
            default: begin
                slots = '0;
                if (r.lc < m_local_limit && r.gc < m_global_limit)
                    slots = (m_local_limit - r.lc < m_global_limit - r.gc) ?
                            m_local_limit - r.lc : m_global_limit - r.gc;
                for (int i = 0; i < m_used && slots > 0 && res.size() < MaxResults; i++) begin
                    if (!m_conn[i] && m_time[i] <= r.now) begin
                        m_conn[i] = 1'b1;
                        res.push_back(outcome(1'b1, m_addr[i], ST_OK));
                        slots--;
                    end
                end
                if (res.size() == 0) res.push_back(outcome(1'b0, '0, ST_OK));
            end
        endcase
        if (r.typed) res[0].st = r.st;
        res[res.size()-1].last = 1'b1;
        foreach (res[i]) pending_results.push_back(res[i]);
    endfunction

    // one command transfer; start stays high across back-to-back transfers
    task automatic issue(t_row r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= r.cmd;
        i_peer_address <= r.addr;
        i_local_connections <= r.lc;
        i_global_connections <= r.gc;
        i_now_time <= r.now;
        do @(posedge i_clk); while (busy);
        predict_command(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_LOCAL_LIMIT:  m_local_limit = data[LimitW-1:0];
            REG_GLOBAL_LIMIT: m_global_limit = data[LimitW-1:0];
            REG_RETRY_DELAY:  m_retry_delay = data[DelayW-1:0];
            default:          m_retry_limit = data[RetryW-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_connect_valid !== e.cv) begin
                    $error("connect_valid exp %0h got %0h", e.cv, o_connect_valid);
                    errors++;
                end
                if (o_connect_address !== e.addr) begin
                    $error("connect_address exp %0h got %0h", e.addr, o_connect_address);
                    errors++;
                end
                if (o_status !== e.st) begin
                    $error("status exp %0h got %0h", e.st, o_status);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0h got %0h", e.last, o_last);
                    errors++;
                end
            end
        end
    end

    t_row directed[] = '{
        '{CMD_TICK,    '0,         10'd0,    10'd0,    32'd0,       1, ST_OK},
        '{CMD_SUCCESS, 48'd5,      10'd0,    10'd0,    32'd0,       1, ST_NOT_FOUND},
        '{CMD_FAILURE, 48'd5,      10'd0,    10'd0,    32'd0,       1, ST_NOT_FOUND},
        '{CMD_ADD,     AddrTop,    10'd0,    10'd0,    32'd0,       1, ST_OK},
        '{CMD_ADD,     '0,         10'd0,    10'd0,    32'd0,       1, ST_OK},
        '{CMD_ADD,     '0,         10'd0,    10'd0,    32'd0,       1, ST_KNOWN},
        '{CMD_ADD,     48'd1234,   10'd0,    10'd0,    32'd0,       1, ST_OK},
        '{CMD_ADD,     48'd77,     10'd0,    10'd0,    32'd0,       1, ST_OK},
        '{CMD_TICK,    '0,         10'd50,   10'd0,    32'd0,       0, ST_OK},
        '{CMD_TICK,    '0,         10'd0,    10'h3ff,  32'd0,       0, ST_OK},
        '{CMD_TICK,    '0,         10'd48,   10'd0,    32'd0,       0, ST_OK},
        '{CMD_TICK,    '0,         10'd0,    10'd0,    32'd0,       0, ST_OK},
        '{CMD_FAILURE, '0,         10'd0,    10'd0,    32'hfffffff0, 1, ST_OK},
        '{CMD_TICK,    '0,         10'd0,    10'd0,    32'hfffffffe, 0, ST_OK},
        '{CMD_TICK,    '0,         10'd0,    10'd0,    TimeTop,     0, ST_OK},
        '{CMD_FAILURE, '0,         10'd0,    10'd0,    32'd100,     1, ST_OK},
        '{CMD_FAILURE, '0,         10'd0,    10'd0,    32'd100,     1, ST_REMOVED},
        '{CMD_SUCCESS, 48'd1234,   10'd0,    10'd0,    32'd100,     1, ST_OK},
        '{CMD_ADD,     48'd999,    10'd0,    10'd0,    32'd100,     1, ST_OK},
        '{CMD_SUCCESS, 48'd999,    10'd0,    10'd0,    32'd100,     1, ST_OK},
        '{CMD_TICK,    '0,         10'h3ff,  10'h3ff,  32'd200,     0, ST_OK},
        '{CMD_SUCCESS, AddrTop,    10'd0,    10'd0,    32'd200,     1, ST_OK}
    };

    initial begin
        logic [CfgDataW-1:0] settings[5][4];
        logic [TimeW-1:0] now;
        t_row r;
        int pick;
        settings[0] = '{16'd1023, 16'd1023, 16'hffff, 16'd15};
        settings[1] = '{16'd0, 16'd200, 16'd0, 16'd1};
        settings[2] = '{16'd3, 16'd2, 16'd7, 16'd0};
        settings[3] = '{CfgDataW'($urandom), CfgDataW'($urandom),
                        CfgDataW'($urandom), CfgDataW'($urandom)};
        settings[4] = '{16'd20, 16'd20, 16'd180, 16'd3};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) issue(directed[k]);
        drain();
        now = 32'd0;
        for (int ph = 0; ph < 5; ph++) begin
            for (int k = 0; k < 4; k++) write_reg(k[CfgIdxW-1:0], settings[ph][k]);
            peer_pool.delete();
            peer_pool.push_back('0);
            peer_pool.push_back(AddrTop);
            repeat (18) peer_pool.push_back(AddrW'({$urandom, $urandom}));
            no_idle = (ph == 2);
            repeat (36) begin
                pick = $urandom_range(0, 99);
                r.typed = 0;
                r.st = ST_OK;
                r.addr = peer_pool[$urandom_range(0, peer_pool.size() - 1)];
                if ($urandom_range(0, 19) == 0) r.addr = AddrW'({$urandom, $urandom});
                r.cmd = pick < 35 ? CMD_ADD : pick < 50 ? CMD_SUCCESS :
                        pick < 75 ? CMD_FAILURE : CMD_TICK;
                if ($urandom_range(0, 3) == 0) begin
                    r.lc = LimitW'($urandom);
                    r.gc = LimitW'($urandom);
                end else begin
                    r.lc = LimitW'($urandom_range(0, 25));
                    r.gc = LimitW'($urandom_range(0, 25));
                end
                if ($urandom_range(0, 29) == 0) now = $urandom;
                else now = now + $urandom_range(0, 300);
                r.now = now;
                issue(r);
            end
            drain();
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
